FILE: rtl/nsfs_pkg.sv
// Package for the NMEA sentence field splitter: result kinds, sentence codes,
// character constants and the sentence tag table.
// No dependencies.
`default_nettype none

package nsfs_pkg;

  // Default sizing of the line store and the field counter.
  localparam int MAX_LINE_DEF  = 256;
  localparam int MAX_FIELD_DEF = 31;

  // Fixed widths of the item fields.
  localparam int RX_W    = 8;
  localparam int KIND_W  = 2;
  localparam int TYPE_W  = 3;
  localparam int FIDX_W  = 5;
  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 9;
  localparam int OUT_W   = 32;

  // Tag geometry.
  localparam int TAG_COUNT = 6;
  localparam int TAG_LEN   = 6;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR = 2'd0,
    KIND_SEP  = 2'd1,
    KIND_EOL  = 2'd2
  } kind_t;

  // Sentence type codes.
  localparam logic [TYPE_W-1:0] TYPE_GGA     = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_GLL     = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_GSA     = 3'd2;
  localparam logic [TYPE_W-1:0] TYPE_GSV     = 3'd3;
  localparam logic [TYPE_W-1:0] TYPE_RMC     = 3'd4;
  localparam logic [TYPE_W-1:0] TYPE_VTG     = 3'd5;
  localparam logic [TYPE_W-1:0] TYPE_UNKNOWN = 3'd6;

  // Characters with a special meaning.
  localparam logic [RX_W-1:0] CH_LF    = 8'h0A;
  localparam logic [RX_W-1:0] CH_CR    = 8'h0D;
  localparam logic [RX_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [RX_W-1:0] CH_STAR  = 8'h2A;

  // Sentence tags, one row per type code, first character first.
  localparam logic [RX_W-1:0] TAG_TABLE [0:TAG_COUNT-1][0:TAG_LEN-1] = '{
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41},  // $GPGGA
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h4C, 8'h4C},  // $GPGLL
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h53, 8'h41},  // $GPGSA
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h53, 8'h56},  // $GPGSV
    '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43},  // $GPRMC
    '{8'h24, 8'h47, 8'h50, 8'h56, 8'h54, 8'h47}   // $GPVTG
  };

endpackage

`default_nettype wire

FILE: rtl/nmea_sentence_field_splitter_top.sv
// An accepted item's result is registered and shown on the out_ channel in the cycle after it is accepted.
// Throughput: one item per cycle; the single result register is refilled in
// the cycle it is taken, so in_tready only drops while a result waits unread.
// Bytes that give no result (tag, carriage return, dropped) still pass the in_ handshake.
// Reset: synchronous, active low; clears the line state and the result slot.
// Top level of the NMEA sentence field splitter; uses nsfs_pkg.
`default_nettype none

module nmea_sentence_field_splitter_top #(
  parameter int MAX_LINE  = nsfs_pkg::MAX_LINE_DEF,
  parameter int MAX_FIELD = nsfs_pkg::MAX_FIELD_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Received characters.
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [nsfs_pkg::RX_W-1:0]  in_tdata,   // [7:0] rx_byte
  // Results.
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // [2:0] sentence_type, [7:3] field_index, [15:8] field_char,
  // [24:16] line_length, [25] line_overflow, [31:26] zero
  output logic [nsfs_pkg::OUT_W-1:0]      out_tdata,
  output logic [nsfs_pkg::KIND_W-1:0]     out_tuser   // [1:0] kind
);
  import nsfs_pkg::*;

  localparam int LPW = $clog2(MAX_LINE + 1);
  localparam int FCW = $clog2(MAX_FIELD + 1);

  // Line state.
  logic [LPW-1:0]       pos_r, pos_nxt;
  logic [TAG_COUNT-1:0] cand_r, cand_nxt;
  logic [FCW-1:0]       fc_r, fc_nxt;
  logic                 ovf_r, ovf_nxt;

  // Result slot.
  logic                 res_vld_r, res_vld_nxt;
  kind_t                res_kind_r, res_kind_nxt;
  logic [TYPE_W-1:0]    res_type_r, res_type_nxt;
  logic [FIDX_W-1:0]    res_fidx_r, res_fidx_nxt;
  logic [CHAR_W-1:0]    res_char_r, res_char_nxt;
  logic [LEN_W-1:0]     res_len_r, res_len_nxt;
  logic                 res_ovf_r, res_ovf_nxt;

  logic                 in_acc;
  logic [LPW-1:0]       pos_inc;
  logic [TYPE_W-1:0]    cur_type;
  logic [LPW+LEN_W-1:0] len_ext;
  logic [FCW+FIDX_W-1:0] fc_ext;
  logic                 in_tag;
  logic                 full;

  // The slot accepts when empty or while its result is being taken.
  assign in_tready = !res_vld_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign pos_inc = pos_r + LPW'(1);
  assign in_tag  = pos_r < LPW'(TAG_LEN);
  assign full    = pos_r >= LPW'(MAX_LINE);
  assign len_ext = {{LEN_W{1'b0}}, pos_r};
  assign fc_ext  = {{FIDX_W{1'b0}}, fc_r};

  // Sentence type: lowest still-matching tag once the whole tag is stored.
  always_comb begin
    cur_type = TYPE_UNKNOWN;
    if (!in_tag) begin
      for (int t = TAG_COUNT - 1; t >= 0; t--) begin
        if (cand_r[t]) begin
          cur_type = TYPE_W'(t);
        end
      end
    end
  end

  // Per-byte decision: state update and the result, if any.
  always_comb begin
    pos_nxt      = pos_r;
    cand_nxt     = cand_r;
    fc_nxt       = fc_r;
    ovf_nxt      = ovf_r;
    res_vld_nxt  = 1'b0;
    res_kind_nxt = KIND_CHAR;
    res_type_nxt = cur_type;
    res_fidx_nxt = fc_ext[FIDX_W-1:0];
    res_char_nxt = '0;
    res_len_nxt  = '0;
    res_ovf_nxt  = 1'b0;
    if (in_tdata == CH_LF) begin
      // Line end reports the line and returns to the reset state.
      res_vld_nxt  = 1'b1;
      res_kind_nxt = KIND_EOL;
      res_len_nxt  = len_ext[LEN_W-1:0];
      res_ovf_nxt  = ovf_r;
      pos_nxt      = '0;
      cand_nxt     = '1;
      fc_nxt       = '0;
      ovf_nxt      = 1'b0;
    end else if (full) begin
      ovf_nxt = 1'b1;
    end else if (in_tag) begin
      // Tag bytes only narrow the candidate set.
      for (int t = 0; t < TAG_COUNT; t++) begin
        if (TAG_TABLE[t][pos_r[2:0]] != in_tdata) begin
          cand_nxt[t] = 1'b0;
        end
      end
      pos_nxt = pos_inc;
    end else begin
      pos_nxt = pos_inc;
      if (in_tdata == CH_COMMA || in_tdata == CH_STAR) begin
        res_vld_nxt  = 1'b1;
        res_kind_nxt = KIND_SEP;
        if (fc_r < FCW'(MAX_FIELD)) begin
          fc_nxt = fc_r + FCW'(1);
        end
      end else if (in_tdata != CH_CR) begin
        res_vld_nxt  = 1'b1;
        res_kind_nxt = KIND_CHAR;
        res_char_nxt = in_tdata;
      end
    end
  end

  // Line state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      cand_r <= '1;
      fc_r   <= '0;
      ovf_r  <= 1'b0;
    end else if (in_acc) begin
      pos_r  <= pos_nxt;
      cand_r <= cand_nxt;
      fc_r   <= fc_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  // Result register: valid flag is control, the rest is payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (in_tready) begin
      res_vld_r <= in_acc && res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_kind_r <= res_kind_nxt;
      res_type_r <= res_type_nxt;
      res_fidx_r <= res_fidx_nxt;
      res_char_r <= res_char_nxt;
      res_len_r  <= res_len_nxt;
      res_ovf_r  <= res_ovf_nxt;
    end
  end

  assign out_tvalid = res_vld_r;
  assign out_tuser  = res_kind_r;
  assign out_tdata  = {6'b0, res_ovf_r, res_len_r, res_char_r, res_fidx_r, res_type_r};

  // A line end always returns the line state to its reset value.
  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tdata == CH_LF |=> pos_r == '0 && fc_r == '0 && !ovf_r && cand_r == '1)
    else $error("line state not cleared after line end");

  // Length and overflow are only reported with a line end.
  a_len_only_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_kind_r != KIND_EOL |-> res_len_r == '0 && !res_ovf_r)
    else $error("line length or overflow set outside a line end");

  // The line never stores more than its capacity.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LPW'(MAX_LINE))
    else $error("line position beyond capacity");

  // A held result stays put while the sink stalls.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

`default_nettype wire

FILE: bench/nmea_sentence_field_splitter_checker.sv
`timescale 1ns / 1ps
// Checker for the NMEA sentence field splitter: predicts every result from the
// characters accepted on the in_ channel and compares the out_ channel with it.
// Uses nsfs_pkg for widths, result kinds, sentence codes and the tag table.
module nmea_sentence_field_splitter_checker #(
  parameter int MAX_LINE  = nsfs_pkg::MAX_LINE_DEF,
  parameter int MAX_FIELD = nsfs_pkg::MAX_FIELD_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [nsfs_pkg::RX_W-1:0]   in_tdata,    // [7:0] rx_byte
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  // [2:0] sentence_type, [7:3] field_index, [15:8] field_char,
  // [24:16] line_length, [25] line_overflow, [31:26] zero
  input  logic [nsfs_pkg::OUT_W-1:0]  out_tdata,
  input  logic [nsfs_pkg::KIND_W-1:0] out_tuser,   // [1:0] kind
  output int                          error_count,
  output int                          results_due
);
  import nsfs_pkg::*;

  localparam int PAD_LSB = TYPE_W + FIDX_W + CHAR_W + LEN_W + 1;

  typedef struct packed {
    kind_t               kind;
    logic [TYPE_W-1:0]   stype;
    logic [FIDX_W-1:0]   fidx;
    logic [CHAR_W-1:0]   chr;
    logic [LEN_W-1:0]    len;
    logic                ovf;
  } field_result_t;

  // Predicted line state.
  int                   line_len;
  logic [TAG_COUNT-1:0] tags_alive;
  int                   seps_seen;
  logic                 chars_dropped;

  field_result_t        pending_fields[$];
  int                   mismatches = 0;

  assign error_count = mismatches;

  task automatic clear_line();
    line_len      = 0;
    tags_alive    = '1;
    seps_seen     = 0;
    chars_dropped = 1'b0;
  endtask

  // The lowest tag still matching wins, but only once the whole tag is in.
  function automatic logic [TYPE_W-1:0] sentence_now();
    logic [TYPE_W-1:0] code;
    code = TYPE_UNKNOWN;
    if (line_len >= TAG_LEN) begin
      for (int t = TAG_COUNT - 1; t >= 0; t--) begin
        if (tags_alive[t]) code = t[TYPE_W-1:0];
      end
    end
    return code;
  endfunction

  // Advances the line state by one character and gives its result, if any.
  task automatic split_char(input logic [RX_W-1:0] c, output bit gives,
                            output field_result_t r);
    r     = '0;
    gives = 1'b0;
    if (c == CH_LF) begin
      r.kind  = KIND_EOL;
      r.stype = sentence_now();
      r.fidx  = seps_seen[FIDX_W-1:0];
      r.len   = line_len[LEN_W-1:0];
      r.ovf   = chars_dropped;
      gives   = 1'b1;
      clear_line();
    end else if (line_len >= MAX_LINE) begin
      chars_dropped = 1'b1;
    end else if (line_len < TAG_LEN) begin
      // Tag characters only narrow the match, even separators.
      for (int t = 0; t < TAG_COUNT; t++) begin
        if (TAG_TABLE[t][line_len] != c) tags_alive[t] = 1'b0;
      end
      line_len++;
    end else begin
      line_len++;
      if (c == CH_COMMA || c == CH_STAR) begin
        r.kind  = KIND_SEP;
        r.stype = sentence_now();
        r.fidx  = seps_seen[FIDX_W-1:0];
        gives   = 1'b1;
        if (seps_seen < MAX_FIELD) seps_seen++;
      end else if (c != CH_CR) begin
        r.kind  = KIND_CHAR;
        r.stype = sentence_now();
        r.fidx  = seps_seen[FIDX_W-1:0];
        r.chr   = c;
        gives   = 1'b1;
      end
    end
  endtask

  function automatic string describe(field_result_t r);
    return $sformatf("kind %0d type %0d field %0d char %h len %0d ovf %0b",
                     r.kind, r.stype, r.fidx, r.chr, r.len, r.ovf);
  endfunction

  task automatic note_error(input string msg);
    if (mismatches < 10) $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Results are compared before the item of the same edge is predicted.
  always @(posedge clk) begin
    field_result_t got;
    field_result_t want;
    field_result_t fresh;
    bit            gives;
    if (!rst_n) begin
      clear_line();
      pending_fields.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.kind  = kind_t'(out_tuser);
        got.stype = out_tdata[TYPE_W-1:0];
        got.fidx  = out_tdata[TYPE_W +: FIDX_W];
        got.chr   = out_tdata[TYPE_W+FIDX_W +: CHAR_W];
        got.len   = out_tdata[TYPE_W+FIDX_W+CHAR_W +: LEN_W];
        got.ovf   = out_tdata[PAD_LSB-1];
        if (pending_fields.size() == 0) begin
          note_error({"result with none expected: ", describe(got)});
        end else begin
          want = pending_fields.pop_front();
          if (got !== want || out_tdata[OUT_W-1:PAD_LSB] !== '0) begin
            note_error($sformatf("result mismatch: expected %s, got %s pad %h",
                                 describe(want), describe(got),
                                 out_tdata[OUT_W-1:PAD_LSB]));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        split_char(in_tdata, gives, fresh);
        if (gives) pending_fields.push_back(fresh);
      end
    end
    results_due <= pending_fields.size();
  end

endmodule

FILE: bench/nmea_sentence_field_splitter_top_test.sv
`timescale 1ns / 1ps
// Testbench top for the NMEA sentence field splitter: drives characters and
// random back-pressure, and gives the verdict from the checker's error count.
// Depends on nsfs_pkg, the block's top level and the checker module.
module nmea_sentence_field_splitter_top_test;
  import nsfs_pkg::*;

  localparam int TOTAL_CHARS = 560;
  localparam int QUIET_FROM  = 480;
  localparam int LONG_AT     = 150;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic [RX_W-1:0]   in_tdata   = '0;
  logic              out_tready = 1'b0;
  logic              in_tready;
  logic              out_tvalid;
  logic [OUT_W-1:0]  out_tdata;
  logic [KIND_W-1:0] out_tuser;

  int errors_seen;
  int results_due;
  int chars_sent = 0;
  bit src_gaps   = 1'b0;
  bit sink_gaps  = 1'b0;
  int sink_hold  = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  nmea_sentence_field_splitter_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  nmea_sentence_field_splitter_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .error_count (errors_seen),
    .results_due (results_due)
  );

  // The receiver stalls now and then, in bursts, while sink_gaps is set.
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold  <= sink_hold - 1;
      out_tready <= 1'b0;
    end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
      sink_hold  <= $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [RX_W-1:0] any_but_lf();
    logic [RX_W-1:0] c;
    do c = RX_W'($urandom_range(0, 255)); while (c == CH_LF);
    return c;
  endfunction

  // Mostly digits and letters, now and then any byte short of a newline.
  function automatic logic [RX_W-1:0] field_char();
    case ($urandom_range(0, 3))
      0:       return any_but_lf();
      1:       return RX_W'(8'h41 + $urandom_range(0, 25));   // 'A' upwards
      default: return RX_W'(8'h30 + $urandom_range(0, 9));    // '0' upwards
    endcase
  endfunction

  // Offers one item, after an optional gap, and waits until it is taken.
  task automatic send_char(input logic [RX_W-1:0] c);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  initial begin
    int              row;
    int              spoil;
    int              nfields;
    int              pick;
    logic [RX_W-1:0] c;
    bit              long_done;
    long_done = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    src_gaps = 1'b1;
    sink_gaps <= 1'b1;

    // Short line whose tag holds separators: no separator results, unknown type.
    send_text("$GP,*");
    send_char(CH_LF);
    // Full sentence with the byte extremes, a star and a carriage return.
    send_text("$GPRMC,");
    send_char(8'h00);
    send_char(CH_STAR);
    send_char(8'hFF);
    send_char(CH_CR);
    send_char(CH_LF);
    // Empty line, then a line that is the tag alone.
    send_char(CH_LF);
    send_text("$GPVTG");
    send_char(CH_LF);

    // Hold the sender back until the block has drained.
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);

    while (chars_sent < TOTAL_CHARS) begin
      if (chars_sent >= QUIET_FROM) begin
        src_gaps = 1'b0;
        sink_gaps <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        src_gaps = 1'($urandom_range(0, 1));
        sink_gaps <= 1'($urandom_range(0, 1));
      end
      pick = $urandom_range(0, 9);
      if (!long_done && chars_sent >= LONG_AT) begin
        // One line past capacity, with enough separators to saturate.
        long_done = 1'b1;
        for (int i = 0; i < TAG_LEN; i++) send_char(TAG_TABLE[TYPE_GSV][i]);
        for (int i = 0; i < MAX_LINE_DEF + 4; i++) begin
          send_char((i % 6 == 5) ? CH_COMMA : field_char());
        end
        send_char(CH_LF);
      end else begin
        case (pick)
          0: begin
            repeat ($urandom_range(1, 8)) send_char(RX_W'($urandom_range(0, 255)));
          end
          1: begin
            repeat ($urandom_range(0, 7)) send_char(any_but_lf());
            send_char(CH_LF);
          end
          default: begin
            // Well-formed sentence; now and then one tag byte is spoilt.
            row   = $urandom_range(0, TAG_COUNT - 1);
            spoil = (pick == 2) ? int'($urandom_range(0, TAG_LEN - 1)) : -1;
            for (int i = 0; i < TAG_LEN; i++) begin
              c = (i == spoil) ? any_but_lf() : TAG_TABLE[row][i];
              send_char(c);
            end
            nfields = $urandom_range(1, 8);
            for (int f = 0; f < nfields; f++) begin
              repeat ($urandom_range(0, 5)) send_char(field_char());
              send_char((f == nfields - 1) ? CH_STAR : CH_COMMA);
            end
            repeat (2) send_char(field_char());
            if ($urandom_range(0, 3) != 0) send_char(CH_CR);
            send_char(CH_LF);
          end
        endcase
      end
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (8) @(posedge clk);
    if (errors_seen == 0 && results_due == 0) begin
      $display("nmea_sentence_field_splitter_top_test: clean");
    end else begin
      $display("nmea_sentence_field_splitter_top_test: errors");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #400000;
    $display("nmea_sentence_field_splitter_top_test: errors");
    $finish;
  end

endmodule
